// ===== rtl/aavr_pkg.sv =====
package aavr_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int MAT_W = 16;
	localparam int MAT_N = 9;
	localparam int FIFO_DEPTH = 4;

	localparam int TH_W = 20;
	localparam int CX_W = 34;
	localparam int ATAN_IDX_W = 5;

	localparam logic signed [TH_W-1:0] PI_Q16 = 20'sd205887;
	localparam logic signed [TH_W-1:0] TWO_PI_Q16 = 20'sd411775;
	localparam logic signed [TH_W-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [CX_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_X = 8'd0,
		REG_AXIS_Y = 8'd1,
		REG_AXIS_Z = 8'd2,
		REG_ANGLE  = 8'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		MB_IDLE,
		MB_LOAD,
		MB_CORDIC,
		MB_TRIG,
		MB_PROD,
		MB_SCALE,
		MB_SUM
	} mb_state_t;

	typedef enum logic [1:0] {
		SGN_ZERO,
		SGN_POS,
		SGN_NEG
	} sgn_t;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} ax_sel_t;

	typedef struct packed {
		ax_sel_t ai;
		ax_sel_t aj;
		ax_sel_t ak;
		logic    diag;
		sgn_t    sgn;
	} ent_sel_t;

	typedef struct packed {
		logic                           valid;
		logic [MAT_N-1:0][MAT_W-1:0]    m;
	} mat_bus_t;

	function automatic logic signed [TH_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
		logic signed [TH_W-1:0] r;
		case (i)
			5'd0:  r = 20'sd51472;
			5'd1:  r = 20'sd30386;
			5'd2:  r = 20'sd16055;
			5'd3:  r = 20'sd8150;
			5'd4:  r = 20'sd4091;
			5'd5:  r = 20'sd2047;
			5'd6:  r = 20'sd1024;
			5'd7:  r = 20'sd512;
			5'd8:  r = 20'sd256;
			5'd9:  r = 20'sd128;
			5'd10: r = 20'sd64;
			5'd11: r = 20'sd32;
			5'd12: r = 20'sd16;
			5'd13: r = 20'sd8;
			5'd14: r = 20'sd4;
			5'd15: r = 20'sd2;
			5'd16: r = 20'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// R = c*I + (1-c)*a*a^T + s*[a]x, row major
	function automatic ent_sel_t ent_sel(input logic [3:0] e);
		ent_sel_t r;
		case (e)
			4'd0: r = '{ai: AX_X, aj: AX_X, ak: AX_X, diag: 1'b1, sgn: SGN_ZERO};
			4'd1: r = '{ai: AX_X, aj: AX_Y, ak: AX_Z, diag: 1'b0, sgn: SGN_NEG};
			4'd2: r = '{ai: AX_X, aj: AX_Z, ak: AX_Y, diag: 1'b0, sgn: SGN_POS};
			4'd3: r = '{ai: AX_X, aj: AX_Y, ak: AX_Z, diag: 1'b0, sgn: SGN_POS};
			4'd4: r = '{ai: AX_Y, aj: AX_Y, ak: AX_X, diag: 1'b1, sgn: SGN_ZERO};
			4'd5: r = '{ai: AX_Y, aj: AX_Z, ak: AX_X, diag: 1'b0, sgn: SGN_NEG};
			4'd6: r = '{ai: AX_X, aj: AX_Z, ak: AX_Y, diag: 1'b0, sgn: SGN_NEG};
			4'd7: r = '{ai: AX_Y, aj: AX_Z, ak: AX_X, diag: 1'b0, sgn: SGN_POS};
			4'd8: r = '{ai: AX_Z, aj: AX_Z, ak: AX_Z, diag: 1'b1, sgn: SGN_ZERO};
			default: r = '{ai: AX_X, aj: AX_X, ak: AX_X, diag: 1'b0, sgn: SGN_ZERO};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/axis_angle_vertex_rotator.sv =====
// Rotates streamed Q16.8 vertices about the unit axis held in axis_x/y/z (Q2.14) by angle
// (Q3.13 radians), using the cached Rodrigues matrix. Once the matrix is cached the block
// takes and delivers one vertex per clock while m_tready is high; a vertex passes the
// product, row-sum and rounded-result registers after leaving the four-word input queue,
// which keeps taking words until full while a result waits. After reset and after each
// write to indices 0 to 3 the matrix is rebuilt by one shared CORDIC stage (one step a
// cycle) and a PROD/SCALE/SUM multiplier chain; vertices queue meanwhile, then flow.
module axis_angle_vertex_rotator
	import aavr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata, // x_in, y_in, z_in, zero fill
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata, // x_out, y_out, z_out, zero fill
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int VW = 3 * COORD_WIDTH;
	localparam int TW = ((VW + 7) / 8) * 8;

	mat_bus_t        mat;
	logic            q_valid, q_pop;
	logic [VW-1:0]   q_data, res;
	logic            cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(REG_ANGLE) + 1'b1);

	aavr_fifo #(
		.WIDTH(VW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (s_tdata[VW-1:0]),
		.out_valid(q_valid),
		.out_pop  (q_pop),
		.out_data (q_data)
	);

	aavr_matrix #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.mat      (mat)
	);

	aavr_rotate #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_rotate (
		.clk      (clk),
		.arst_n   (arst_n),
		.mat      (mat),
		.in_valid (q_valid),
		.in_pop   (q_pop),
		.in_data  (q_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (res)
	);

	assign m_tdata = TW'(res);

endmodule

// ===== rtl/aavr_fifo.sv =====
module aavr_fifo
	import aavr_pkg::*;
#(
	parameter int WIDTH = 3 * COORD_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_pop,
	output logic [WIDTH-1:0] out_data
);

	localparam int AW = $clog2(FIFO_DEPTH);

	logic [WIDTH-1:0] mem_q [FIFO_DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push, pop;

	assign in_ready  = count_q != (AW+1)'(FIFO_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/aavr_matrix.sv =====
module aavr_matrix
	import aavr_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output mat_bus_t              mat
);

	localparam int STW = $clog2(CORDIC_STEPS);

	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q, angle_q;
	mb_state_t          state_q, state_d;
	logic               valid_q, valid_d;
	logic [STW-1:0]     step_q;
	logic [3:0]         ent_q;
	logic               neg_q;

	logic signed [TH_W-1:0] th_q;
	logic signed [CX_W-1:0] x_q, y_q;
	logic signed [15:0]     c_q, s_q;
	logic signed [16:0]     omc_q;
	logic signed [31:0]     pa_q, pb_q;
	logic signed [48:0]     pc_q;
	logic signed [15:0]     cache_q [MAT_N];

	// angle load and fold into [-pi/2, pi/2]
	logic signed [TH_W-1:0] th_raw, th_wrap, th_fold;
	logic                   fold;
	logic signed [TH_W-1:0] atan_v;
	logic signed [CX_W-1:0] dx, dy;
	logic signed [CX_W-1:0] xn, yn, xr, yr;
	logic signed [15:0]     c_v, s_v;
	ent_sel_t               sel;
	logic signed [15:0]     ai_v, aj_v, ak_v;
	logic signed [50:0]     sum_v, rnd_v;
	logic signed [15:0]     ent_v;

	function automatic logic signed [15:0] pick(input ax_sel_t k, input logic signed [15:0] ax,
			input logic signed [15:0] ay, input logic signed [15:0] az);
		logic signed [15:0] r;
		case (k)
			AX_X:    r = ax;
			AX_Y:    r = ay;
			AX_Z:    r = az;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] q14_clamp(input logic signed [CX_W-1:0] v);
		logic signed [CX_W-1:0] t;
		logic signed [15:0]     r;
		t = (v + CX_W'(32768)) >>> 16;
		if (t > CX_W'(16384)) begin
			r = 16'sd16384;
		end else if (t < -CX_W'(16384)) begin
			r = -16'sd16384;
		end else begin
			r = t[15:0];
		end
		return r;
	endfunction

	always_comb begin
		th_raw = TH_W'(angle_q) <<< 3;
		if (th_raw > PI_Q16) begin
			th_wrap = th_raw - TWO_PI_Q16;
		end else if (th_raw < -PI_Q16) begin
			th_wrap = th_raw + TWO_PI_Q16;
		end else begin
			th_wrap = th_raw;
		end
		fold = 1'b0;
		if (th_wrap > HALF_PI_Q16) begin
			th_fold = th_wrap - PI_Q16;
			fold = 1'b1;
		end else if (th_wrap < -HALF_PI_Q16) begin
			th_fold = th_wrap + PI_Q16;
			fold = 1'b1;
		end else begin
			th_fold = th_wrap;
		end
	end

	assign atan_v = atan_q16(ATAN_IDX_W'(step_q));
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign xn = neg_q ? -x_q : x_q;
	assign yn = neg_q ? -y_q : y_q;
	assign c_v = q14_clamp(xn);
	assign s_v = q14_clamp(yn);
	assign xr = xn;
	assign yr = yn;

	assign sel  = ent_sel(ent_q);
	assign ai_v = pick(sel.ai, axis_x_q, axis_y_q, axis_z_q);
	assign aj_v = pick(sel.aj, axis_x_q, axis_y_q, axis_z_q);
	assign ak_v = pick(sel.ak, axis_x_q, axis_y_q, axis_z_q);

	always_comb begin
		sum_v = 51'(pc_q);
		if (sel.diag) begin
			sum_v = sum_v + (51'(c_q) <<< 28);
		end
		case (sel.sgn)
			SGN_POS: sum_v = sum_v + (51'(pb_q) <<< 14);
			SGN_NEG: sum_v = sum_v - (51'(pb_q) <<< 14);
			default: sum_v = sum_v;
		endcase
		rnd_v = (sum_v + 51'sd134217728) >>> 28;
		if (rnd_v > 51'sd32767) begin
			ent_v = 16'sh7fff;
		end else if (rnd_v < -51'sd32768) begin
			ent_v = 16'sh8000;
		end else begin
			ent_v = rnd_v[15:0];
		end
	end

	always_comb begin
		state_d = state_q;
		valid_d = valid_q;
		case (state_q)
			MB_IDLE:   state_d = MB_IDLE;
			MB_LOAD:   state_d = MB_CORDIC;
			MB_CORDIC: begin
				if (step_q == STW'(CORDIC_STEPS - 1)) begin
					state_d = MB_TRIG;
				end
			end
			MB_TRIG:   state_d = MB_PROD;
			MB_PROD:   state_d = MB_SCALE;
			MB_SCALE:  state_d = MB_SUM;
			MB_SUM: begin
				if (ent_q == 4'(MAT_N - 1)) begin
					state_d = MB_IDLE;
					valid_d = 1'b1;
				end else begin
					state_d = MB_PROD;
				end
			end
			default:   state_d = MB_IDLE;
		endcase
		if (cfg_wr) begin
			state_d = MB_LOAD;
			valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MB_LOAD;
			valid_q  <= 1'b0;
			axis_x_q <= 16'sd0;
			axis_y_q <= 16'sd0;
			axis_z_q <= 16'sd16384;
			angle_q  <= 16'sd0;
			step_q   <= '0;
			ent_q    <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			if (cfg_wr) begin
				case (reg_idx_t'(cfg_index))
					REG_AXIS_X: axis_x_q <= cfg_data;
					REG_AXIS_Y: axis_y_q <= cfg_data;
					REG_AXIS_Z: axis_z_q <= cfg_data;
					REG_ANGLE:  angle_q  <= cfg_data;
					default:    angle_q  <= angle_q;
				endcase
			end
			case (state_q)
				MB_LOAD:   step_q <= '0;
				MB_CORDIC: step_q <= step_q + 1'b1;
				MB_TRIG:   ent_q  <= '0;
				MB_SUM:    ent_q  <= ent_q + 1'b1;
				default:   step_q <= step_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MB_LOAD: begin
				th_q  <= th_fold;
				neg_q <= fold;
				x_q   <= CORDIC_GAIN_Q30;
				y_q   <= '0;
			end
			MB_CORDIC: begin
				if (th_q >= 0) begin
					x_q  <= x_q - dx;
					y_q  <= y_q + dy;
					th_q <= th_q - atan_v;
				end else begin
					x_q  <= x_q + dx;
					y_q  <= y_q - dy;
					th_q <= th_q + atan_v;
				end
			end
			MB_TRIG: begin
				c_q   <= c_v;
				s_q   <= s_v;
				omc_q <= 17'sd16384 - 17'(c_v);
				x_q   <= xr;
				y_q   <= yr;
			end
			MB_PROD: begin
				pa_q <= 32'(ai_v) * 32'(aj_v);
				pb_q <= 32'(ak_v) * 32'(s_q);
			end
			MB_SCALE: pc_q <= 49'(pa_q) * 49'(omc_q);
			MB_SUM:   cache_q[ent_q] <= ent_v;
			default:  pc_q <= pc_q;
		endcase
	end

	always_comb begin
		mat.valid = valid_q;
		for (int i = 0; i < MAT_N; i++) begin
			mat.m[i] = cache_q[i];
		end
	end

	a_valid_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> state_q == MB_IDLE)
		else $error("matrix valid outside idle");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == MB_CORDIC && step_q == STW'(CORDIC_STEPS - 1) && !cfg_wr)
		|=> state_q == MB_TRIG)
		else $error("cordic did not finish after its step count");

	a_valid_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_q) |-> $past(state_q) == MB_SUM && $past(ent_q) == 4'(MAT_N - 1))
		else $error("matrix valid without all entries written");

endmodule

// ===== rtl/aavr_rotate.sv =====
module aavr_rotate
	import aavr_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mat_bus_t                   mat,
	input  logic                       in_valid,
	output logic                       in_pop,
	input  logic [3*COORD_WIDTH-1:0]   in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [3*COORD_WIDTH-1:0]   out_data
);

	localparam int CW = COORD_WIDTH;
	localparam int PW = MAT_W + CW;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] LO = -HI - SW'(1);
	localparam logic signed [SW-1:0] RND = SW'(8192);

	logic                 en;
	logic                 v_s1, v_s2, v_s3;
	logic signed [PW-1:0] prod_s1 [MAT_N];
	logic signed [SW-1:0] sum_s2 [3];
	logic [3*CW-1:0]      res_s3;
	logic signed [SW-1:0] rnd [3];
	logic [3*CW-1:0]      res_d;

	assign en        = !(v_s3 && !out_ready);
	assign in_pop    = en && in_valid && mat.valid;
	assign out_valid = v_s3;
	assign out_data  = res_s3;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			rnd[r] = (sum_s2[r] + RND) >>> 14;
			if (rnd[r] > HI) begin
				res_d[r*CW +: CW] = HI[CW-1:0];
			end else if (rnd[r] < LO) begin
				res_d[r*CW +: CW] = LO[CW-1:0];
			end else begin
				res_d[r*CW +: CW] = rnd[r][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r*3+k] <= PW'($signed(mat.m[r*3+k])) *
						PW'($signed(in_data[k*CW +: CW]));
				end
				sum_s2[r] <= SW'(prod_s1[r*3]) + SW'(prod_s1[r*3+1]) + SW'(prod_s1[r*3+2]);
			end
			res_s3 <= res_d;
		end
	end

endmodule
